// File: design/skrle_pkg.sv
// shared types and constants of the skip/run line decoder
package skrle_pkg;

  localparam int ADDR_BITS     = 26;
  localparam int CFG_ADDR_BITS = 3;
  localparam int OUT_DATA_BITS = 48;

  localparam int RST_REGION_WIDTH  = 320;
  localparam int RST_REGION_HEIGHT = 200;
  localparam int RST_ORIGIN_X      = 0;
  localparam int RST_ORIGIN_Y      = 0;
  localparam int RST_LINE_PITCH    = 320;

  localparam logic [ADDR_BITS-1:0] RST_FRAME_BASE =
    ADDR_BITS'(RST_ORIGIN_Y * RST_LINE_PITCH + RST_ORIGIN_X);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_REGION_WIDTH  = 3'd0,
    CFG_REGION_HEIGHT = 3'd1,
    CFG_ORIGIN_X      = 3'd2,
    CFG_ORIGIN_Y      = 3'd3,
    CFG_LINE_PITCH    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       data_last;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]           run_length;
    logic [7:0]           pixel_value;
    logic [ADDR_BITS-1:0] pixel_address;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int OUT_PAD     = OUT_DATA_BITS - RESULT_BITS;

endpackage

// File: design/skrle_cfg.sv
// configuration registers and frame base address of the skip/run line decoder
module skrle_cfg
  import skrle_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS:0]     cfg_data,
  output logic [COORD_BITS-1:0]   region_width,
  output logic [COORD_BITS-1:0]   region_height,
  output logic [COORD_BITS:0]     line_pitch,
  output logic [ADDR_BITS-1:0]    frame_base
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int BW = (PW > ADDR_BITS) ? PW : ADDR_BITS;

  logic [COORD_BITS-1:0] width_r, width_nxt;
  logic [COORD_BITS-1:0] height_r, height_nxt;
  logic [COORD_BITS-1:0] ox_r, ox_nxt;
  logic [COORD_BITS-1:0] oy_r, oy_nxt;
  logic [COORD_BITS:0]   pitch_r, pitch_nxt;
  logic [ADDR_BITS-1:0]  base_r;
  logic [PW-1:0]         prod;
  logic [BW-1:0]         base_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    pitch_nxt  = pitch_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_REGION_WIDTH:  width_nxt  = cfg_data[COORD_BITS-1:0];
        CFG_REGION_HEIGHT: height_nxt = cfg_data[COORD_BITS-1:0];
        CFG_ORIGIN_X:      ox_nxt     = cfg_data[COORD_BITS-1:0];
        CFG_ORIGIN_Y:      oy_nxt     = cfg_data[COORD_BITS-1:0];
        CFG_LINE_PITCH:    pitch_nxt  = cfg_data;
        default: ;
      endcase
    end
    prod      = PW'(oy_nxt) * PW'(pitch_nxt);
    base_full = BW'(prod) + BW'(ox_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= COORD_BITS'(RST_REGION_WIDTH);
      height_r <= COORD_BITS'(RST_REGION_HEIGHT);
      ox_r     <= COORD_BITS'(RST_ORIGIN_X);
      oy_r     <= COORD_BITS'(RST_ORIGIN_Y);
      pitch_r  <= (COORD_BITS + 1)'(RST_LINE_PITCH);
      base_r   <= RST_FRAME_BASE;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      pitch_r  <= pitch_nxt;
      base_r   <= base_full[ADDR_BITS-1:0];
    end
  end

  assign region_width  = width_r;
  assign region_height = height_r;
  assign line_pitch    = pitch_r;
  assign frame_base    = base_r;

endmodule

// File: design/skrle_core.sv
// byte parser state machine and result register of the skip/run line decoder
module skrle_core
  import skrle_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  item_ready,
  input  logic [COORD_BITS-1:0] region_width,
  input  logic [COORD_BITS-1:0] region_height,
  input  logic [COORD_BITS:0]   line_pitch,
  input  logic [ADDR_BITS-1:0]  frame_base,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               result
);

  localparam int CW = COORD_BITS + 1;
  localparam int XW = ((CW > 16) ? CW : 16) + 1;

  typedef enum logic [3:0] {
    PH_LEN_LO, PH_LEN_HI, PH_SKIP_LO, PH_SKIP_HI, PH_RUN_LO, PH_RUN_HI,
    PH_CODE, PH_COLOR, PH_LITERAL, PH_DISCARD
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [15:0]           line_r, line_nxt;
  logic [15:0]           run_r, run_nxt;
  logic [7:0]            latch_r, latch_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [COORD_BITS-1:0] rows_r, rows_nxt;
  logic [ADDR_BITS-1:0]  base_r, base_nxt;
  logic [7:0]            pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               result_r, result_nxt;

  logic          take;
  logic          emit;
  logic [7:0]    emit_value;
  logic [7:0]    emit_count;
  logic [7:0]    b;
  logic [15:0]   word;
  logic [15:0]   line_dec;
  logic [15:0]   run_dec;
  logic [15:0]   run_new;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] col_new;
  logic [XW-1:0] skip_x;
  logic [7:0]    num;
  logic [7:0]    num_c;
  logic [7:0]    pend_dec;
  logic [CW:0]   room;
  logic          row_end;

  function automatic phase_t next_pair(logic [15:0] line, logic [CW-1:0] col,
                                       logic [CW-1:0] wid);
    phase_t ph;
    if (line >= 16'd2 && col < wid) ph = PH_SKIP_LO;
    else ph = PH_DISCARD;
    return ph;
  endfunction

  function automatic phase_t run_continue(logic [15:0] run, logic [15:0] line,
                                          logic [CW-1:0] col, logic [CW-1:0] wid);
    phase_t ph;
    if (run != 16'd0 && col < wid) ph = PH_CODE;
    else ph = next_pair(line, col, wid);
    return ph;
  endfunction

  assign take       = item_valid && (!out_valid_r || out_ready);
  assign item_ready = !out_valid_r || out_ready;
  assign b          = item.data_byte;
  assign word       = {b, latch_r};
  assign line_dec   = line_r - 16'd1;
  assign run_dec    = run_r - 16'd1;
  assign width_ext  = CW'(region_width);
  assign skip_x     = XW'(col_r) + XW'(word);
  assign run_new    = (word < line_dec) ? word : line_dec;
  assign num        = {1'b0, b[7:1]} + 8'd1;
  assign room       = (CW + 1)'(region_width) - (CW + 1)'(col_r);
  assign num_c      = (!room[CW] && CW'(num) > room[CW-1:0]) ? room[7:0] : num;
  assign pend_dec   = pend_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    line_nxt   = line_r;
    run_nxt    = run_r;
    latch_nxt  = latch_r;
    col_nxt    = col_r;
    rows_nxt   = rows_r;
    base_nxt   = base_r;
    pend_nxt   = pend_r;
    emit       = 1'b0;
    emit_value = 8'd0;
    emit_count = 8'd0;
    col_new    = col_r;
    row_end    = 1'b0;

    if (take) begin
      unique case (phase_r)
        PH_LEN_LO: begin
          if (rows_r == '0) base_nxt = frame_base;
          if (rows_r < region_height) begin
            latch_nxt = b;
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          col_nxt = '0;
          if (word == 16'd0) begin
            row_end = 1'b1;
          end else begin
            line_nxt  = word;
            phase_nxt = next_pair(word, '0, width_ext);
          end
        end
        default: begin
          line_nxt = line_dec;
          unique case (phase_r) inside
            PH_SKIP_LO, PH_RUN_LO: begin
              latch_nxt = b;
              phase_nxt = (phase_r == PH_SKIP_LO) ? PH_SKIP_HI : PH_RUN_HI;
            end
            PH_SKIP_HI: begin
              if (line_dec < 16'd2 || skip_x >= XW'(region_width)) begin
                phase_nxt = PH_DISCARD;
              end else begin
                col_nxt   = skip_x[CW-1:0];
                phase_nxt = PH_RUN_LO;
              end
            end
            PH_RUN_HI: begin
              run_nxt   = run_new;
              phase_nxt = run_continue(run_new, line_dec, col_r, width_ext);
            end
            PH_CODE: begin
              run_nxt = run_dec;
              if (b[0]) begin
                if (run_dec == 16'd0 || item.data_last) begin
                  emit       = 1'b1;
                  emit_count = num_c;
                  col_new    = col_r + CW'(num_c);
                  col_nxt    = col_new;
                  phase_nxt  = run_continue(run_dec, line_dec, col_new, width_ext);
                end else begin
                  pend_nxt  = num_c;
                  phase_nxt = PH_COLOR;
                end
              end else begin
                pend_nxt = num_c;
                if (run_dec != 16'd0) phase_nxt = PH_LITERAL;
                else phase_nxt = run_continue(run_dec, line_dec, col_r, width_ext);
              end
            end
            PH_COLOR: begin
              run_nxt    = run_dec;
              emit       = 1'b1;
              emit_value = b;
              emit_count = pend_r;
              col_new    = col_r + CW'(pend_r);
              col_nxt    = col_new;
              pend_nxt   = 8'd0;
              phase_nxt  = run_continue(run_dec, line_dec, col_new, width_ext);
            end
            PH_LITERAL: begin
              run_nxt    = run_dec;
              emit       = 1'b1;
              emit_value = b;
              emit_count = 8'd1;
              col_new    = col_r + CW'(1);
              col_nxt    = col_new;
              pend_nxt   = pend_dec;
              if (pend_dec == 8'd0 || run_dec == 16'd0) begin
                pend_nxt  = 8'd0;
                phase_nxt = run_continue(run_dec, line_dec, col_new, width_ext);
              end
            end
            default: ;
          endcase
          if (line_dec == 16'd0) row_end = 1'b1;
        end
      endcase

      if (row_end) begin
        rows_nxt  = rows_r + COORD_BITS'(1);
        base_nxt  = base_r + ADDR_BITS'(line_pitch);
        col_nxt   = '0;
        run_nxt   = 16'd0;
        line_nxt  = 16'd0;
        phase_nxt = PH_LEN_LO;
      end

      // end of data restarts the frame
      if (item.data_last) begin
        phase_nxt = PH_LEN_LO;
        line_nxt  = 16'd0;
        run_nxt   = 16'd0;
        latch_nxt = 8'd0;
        col_nxt   = '0;
        rows_nxt  = '0;
        base_nxt  = frame_base;
        pend_nxt  = 8'd0;
      end
    end

    result_nxt = result_r;
    if (take) begin
      out_valid_nxt = emit;
      if (emit) begin
        result_nxt.pixel_address = base_r + ADDR_BITS'(col_r);
        result_nxt.pixel_value   = emit_value;
        result_nxt.run_length    = emit_count;
      end
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN_LO;
      line_r      <= 16'd0;
      run_r       <= 16'd0;
      latch_r     <= 8'd0;
      col_r       <= '0;
      rows_r      <= '0;
      base_r      <= RST_FRAME_BASE;
      pend_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      line_r      <= line_nxt;
      run_r       <= run_nxt;
      latch_r     <= latch_nxt;
      col_r       <= col_nxt;
      rows_r      <= rows_nxt;
      base_r      <= base_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    take && emit |-> phase_r == PH_CODE || phase_r == PH_COLOR || phase_r == PH_LITERAL)
    else $error("result from a non-pixel phase");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.data_last |=> phase_r == PH_LEN_LO && rows_r == '0 && col_r == '0)
    else $error("end of data did not restart the frame");

  a_literal_single: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_LITERAL |=> out_valid_r && result_r.run_length == 8'd1)
    else $error("literal byte not written as a single pixel");

  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_LEN_HI && b == 8'd0 && latch_r == 8'd0
    |=> phase_r == PH_LEN_LO && !out_valid_r)
    else $error("empty line did not end the row");

endmodule

// File: design/skip_rle_line_decoder_top.sv
// top level of the skip/run line decoder: input register, parser and configuration
// path: a byte accepted at the input goes into the input register; the parser takes it from there
//   once no result waits on out_tready, updating its state and the result register with its pixel write
// throughput: one compressed byte per cycle while no pending result waits on out_tready
// reset: synchronous active-low rst_n restores the register defaults and the frame start,
//   with no clearing pass
module skip_rle_line_decoder_top
  import skrle_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // data_byte
  input  logic                     in_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // zero pad, run_length, pixel_value, pixel_address (MSB to LSB)
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS:0]      cfg_data
);

  logic                  in_valid_r;
  item_t                 item_r;
  logic                  item_ready;
  logic [COORD_BITS-1:0] region_width;
  logic [COORD_BITS-1:0] region_height;
  logic [COORD_BITS:0]   line_pitch;
  logic [ADDR_BITS-1:0]  frame_base;
  result_t               result;

  assign in_tready = !in_valid_r || item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{data_last: in_tlast, data_byte: in_tdata};
    end
  end

  skrle_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .region_width (region_width),
    .region_height(region_height),
    .line_pitch   (line_pitch),
    .frame_base   (frame_base)
  );

  skrle_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_valid_r),
    .item         (item_r),
    .item_ready   (item_ready),
    .region_width (region_width),
    .region_height(region_height),
    .line_pitch   (line_pitch),
    .frame_base   (frame_base),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result       (result)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, result};

endmodule
